@@ design/npm_pkg.sv @@
// Shared constants and types for the nearest point matcher.
package npm_pkg;

  localparam int MaxPoints = 64;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CountW    = 7;
  localparam int CoordW    = 14;
  localparam int SqW       = 2 * CoordW;
  localparam int DistW     = 30;
  localparam int CfgIdxW   = 1;

  localparam logic [CountW-1:0] CountMax     = CountW'(MaxPoints);
  localparam logic [CountW-1:0] CountReset   = CountW'(64);
  localparam logic [DistW-1:0]  ThreshReset  = DistW'(25600);
  localparam logic [DistW-1:0]  NoMatchDist  = {DistW{1'b1}};

  // input command codes
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegPointCount  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegFarThresh   = CfgIdxW'(1);

  // running search result that travels down the cell row
  typedef struct packed {
    logic             valid;
    logic [DistW-1:0] best_dist;
    logic [IdxW-1:0]  best_idx;
  } wave_t;

  // candidate load broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } load_t;

endpackage

@@ design/npm_cell.sv @@
// One cell of the row: holds a candidate point and updates the passing search wave.
module npm_cell import npm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [IdxW-1:0]   cell_idx_i,
  input  logic [CountW-1:0] count_i,
  input  load_t             load_i,
  input  logic [CoordW-1:0] query_x_i,
  input  logic [CoordW-1:0] query_y_i,
  input  wave_t             wave_i,
  output wave_t             wave_o
);

  logic [CoordW-1:0] cand_x_q, cand_y_q;
  logic [CoordW-1:0] dx, dy;
  logic [SqW-1:0]    sq_x, sq_y;
  logic [DistW-1:0]  dist_sq;
  logic              active;
  logic              take;
  wave_t             wave_d, wave_q;

  // candidate storage, written only by a load addressed to this cell
  always_ff @(posedge clk_i) begin
    if (load_i.en && (load_i.idx == cell_idx_i)) begin
      cand_x_q <= load_i.x;
      cand_y_q <= load_i.y;
    end
  end

  always_comb begin
    dx      = (query_x_i >= cand_x_q) ? (query_x_i - cand_x_q) : (cand_x_q - query_x_i);
    dy      = (query_y_i >= cand_y_q) ? (query_y_i - cand_y_q) : (cand_y_q - query_y_i);
    sq_x    = dx * dx;
    sq_y    = dy * dy;
    dist_sq = DistW'(sq_x) + DistW'(sq_y);
    active  = ({1'b0, cell_idx_i} < count_i);
    // strict compare: on a tie the earlier cell keeps the match
    take    = wave_i.valid && active && (dist_sq < wave_i.best_dist);
    wave_d  = wave_i;
    if (take) begin
      wave_d.best_dist = dist_sq;
      wave_d.best_idx  = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= '0;
    end else begin
      wave_q <= wave_d;
    end
  end

  assign wave_o = wave_q;

endmodule

@@ design/nearest_point_matcher_unit.sv @@
// Top level of the nearest point matcher: control, configuration and the cell row.
//
// Brute-force 2D nearest-point search. A load beat (cmd 0) stores x/y into the
// cell named by point_index. A query beat (cmd 1) sends a search wave down a
// row of 64 cells, one cell per cycle; each cell holds one candidate, forms
// dx*dx + dy*dy against the query point and keeps the strictly smaller
// distance, so ties go to the lower slot. Only the first point_count cells
// (clamped to 64) take part. The wave always walks the full row: the accepted
// query is registered in start_q, each of the 64 cells registers the wave in
// turn, and the result register captures it at the end. One beat is in work
// at a time: in_stall_o stays high from a query accept until its result beat
// has been taken. With point_count 0 the result is slot 0, distance all ones
// and too_far set. Coordinates are Q10.4 pixels, distances carry 8 fraction
// bits. Configuration may be written only while no query is outstanding. Slots
// must be loaded before a query searches them.
module nearest_point_matcher_unit import npm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DistW-1:0]   cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [IdxW-1:0]    point_index_i,
  input  logic [CoordW-1:0]  x_coord_i,
  input  logic [CoordW-1:0]  y_coord_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [IdxW-1:0]    ref_index_o,
  output logic [IdxW-1:0]    best_index_o,
  output logic [DistW-1:0]   min_dist_sq_o,
  output logic               too_far_o
);

  logic [CountW-1:0] point_count_q;
  logic [DistW-1:0]  far_thresh_q;
  logic [CountW-1:0] count_eff;

  logic              busy_q;
  logic              start_q;
  logic [IdxW-1:0]   ref_idx_q;
  logic [CoordW-1:0] query_x_q, query_y_q;

  logic              in_fire, out_fire, query_fire;
  load_t             load;
  wave_t             wave [MaxPoints+1];

  logic              out_valid_q;
  logic [IdxW-1:0]   out_ref_q, out_best_q;
  logic [DistW-1:0]  out_dist_q;
  logic              out_far_q;

  assign in_stall_o = busy_q;
  assign in_fire    = in_valid_i && !busy_q;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign query_fire = in_fire && (cmd_i == CmdQuery);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= CountReset;
      far_thresh_q  <= ThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegPointCount: point_count_q <= cfg_wdata_i[CountW-1:0];
        RegFarThresh:  far_thresh_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign count_eff = (point_count_q > CountMax) ? CountMax : point_count_q;

  // busy from query accept until its result beat leaves
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      start_q <= 1'b0;
    end else begin
      start_q <= query_fire;
      if (query_fire) begin
        busy_q <= 1'b1;
      end else if (out_fire) begin
        busy_q <= 1'b0;
      end
    end
  end

  // query point held steady while the wave runs
  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      ref_idx_q <= point_index_i;
      query_x_q <= x_coord_i;
      query_y_q <= y_coord_i;
    end
  end

  always_comb begin
    load.en  = in_fire && (cmd_i == CmdLoad);
    load.idx = point_index_i;
    load.x   = x_coord_i;
    load.y   = y_coord_i;
  end

  // wave enters cell 0 with no match yet
  always_comb begin
    wave[0].valid     = start_q;
    wave[0].best_dist = NoMatchDist;
    wave[0].best_idx  = '0;
  end

  for (genvar k = 0; k < MaxPoints; k++) begin : g_cell
    npm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IdxW'(k)),
      .count_i    (count_eff),
      .load_i     (load),
      .query_x_i  (query_x_q),
      .query_y_i  (query_y_q),
      .wave_i     (wave[k]),
      .wave_o     (wave[k+1])
    );
  end

  // result register, filled when the wave leaves the last cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wave[MaxPoints].valid) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wave[MaxPoints].valid) begin
      out_ref_q  <= ref_idx_q;
      out_best_q <= wave[MaxPoints].best_idx;
      out_dist_q <= wave[MaxPoints].best_dist;
      out_far_q  <= (count_eff == '0) || (wave[MaxPoints].best_dist > far_thresh_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ref_index_o   = out_ref_q;
  assign best_index_o  = out_best_q;
  assign min_dist_sq_o = out_dist_q;
  assign too_far_o     = out_far_q;

endmodule

@@ dv/nearest_point_matcher_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for nearest_point_matcher_unit: directed corners, then random phases.
module nearest_point_matcher_unit_tb;
  import npm_pkg::*;

  localparam int ClkHalf      = 2;       // 4 ns period
  localparam int ResetCycles  = 8;
  // A query walks the full 64-cell row before its result appears. Loads give no
  // result, so before a register write we let the row drain this long.
  localparam int SettleCycles = 70;
  // Worst case is 519 queries, each walking the full row, plus stalls, gaps and
  // settles; this is several times that.
  localparam int CycleLimit   = 500000;
  localparam int CoordMax     = (1 << CoordW) - 1;

  // One expected or observed match beat.
  typedef struct packed {
    logic [IdxW-1:0]  ref_idx;
    logic [IdxW-1:0]  best_idx;
    logic [DistW-1:0] dist_sq;
    logic             far;
  } match_t;

  // Shadow of the candidate table and registers, plus the queue of matches that
  // the block still owes us.
  class match_scoreboard;
    logic [CoordW-1:0] pt_x [MaxPoints];
    logic [CoordW-1:0] pt_y [MaxPoints];
    logic [CountW-1:0] count;
    logic [DistW-1:0]  thresh;
    match_t            due_q [$];
    int                errors;
    int                checked;

    function new();
      count   = CountReset;
      thresh  = ThreshReset;
      errors  = 0;
      checked = 0;
      foreach (pt_x[i]) begin
        pt_x[i] = '0;
        pt_y[i] = '0;
      end
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [DistW-1:0] val);
      if (idx == RegPointCount) count = val[CountW-1:0];
      else if (idx == RegFarThresh) thresh = val;
    endfunction

    // Slots taken into a search: point_count clamped to the table size.
    function int searched();
      return (count > CountMax) ? MaxPoints : int'(count);
    endfunction

    // Brute-force scan; strict less-than keeps the lower slot on a tie.
    function match_t nearest(logic [IdxW-1:0] idx, logic [CoordW-1:0] x,
                             logic [CoordW-1:0] y);
      match_t            m;
      int                n;
      logic [CoordW-1:0] dx;
      logic [CoordW-1:0] dy;
      logic [DistW-1:0]  d;
      n          = searched();
      m.ref_idx  = idx;
      m.best_idx = '0;
      m.dist_sq  = NoMatchDist;
      for (int j = 0; j < n; j++) begin
        dx = (x >= pt_x[j]) ? x - pt_x[j] : pt_x[j] - x;
        dy = (y >= pt_y[j]) ? y - pt_y[j] : pt_y[j] - y;
        d  = DistW'(dx) * DistW'(dx) + DistW'(dy) * DistW'(dy);
        if (d < m.dist_sq) begin
          m.dist_sq  = d;
          m.best_idx = IdxW'(j);
        end
      end
      m.far = (n == 0) || (m.dist_sq > thresh);
      return m;
    endfunction

    function void note_input(logic cmd, logic [IdxW-1:0] idx, logic [CoordW-1:0] x,
                             logic [CoordW-1:0] y);
      if (cmd == CmdLoad) begin
        pt_x[idx] = x;
        pt_y[idx] = y;
      end else begin
        due_q.push_back(nearest(idx, x, y));
      end
    endfunction

    function void check_result(match_t got);
      match_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: match beat with none expected, actual ref %0d best %0d dist %0d",
                 $time, got.ref_idx, got.best_idx, got.dist_sq);
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got.ref_idx !== want.ref_idx) begin
        errors++;
        $display("%0t: ref_index expected %0d actual %0d", $time, want.ref_idx, got.ref_idx);
      end
      if (got.best_idx !== want.best_idx) begin
        errors++;
        $display("%0t: best_index expected %0d actual %0d", $time, want.best_idx,
                 got.best_idx);
      end
      if (got.dist_sq !== want.dist_sq) begin
        errors++;
        $display("%0t: min_dist_sq expected %0d actual %0d", $time, want.dist_sq,
                 got.dist_sq);
      end
      if (got.far !== want.far) begin
        errors++;
        $display("%0t: too_far expected %0d actual %0d", $time, want.far, got.far);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DistW-1:0]   cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               cmd_i;
  logic [IdxW-1:0]    point_index_i;
  logic [CoordW-1:0]  x_coord_i;
  logic [CoordW-1:0]  y_coord_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [IdxW-1:0]    ref_index_o;
  logic [IdxW-1:0]    best_index_o;
  logic [DistW-1:0]   min_dist_sq_o;
  logic               too_far_o;

  match_scoreboard sb;
  bit              quiet;      // no idling on either side while set
  int              n_loads;
  int              n_queries;
  int              n_settings;
  int              cycles = 0;

  nearest_point_matcher_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // Receiver: stall at random, never during the quiet stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 8);
  end

  // Result monitor: a beat moves when valid is high and we are not stalling.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{ref_idx: ref_index_o, best_idx: best_index_o,
                        dist_sq: min_dist_sq_o, far: too_far_o});
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d matches still due", cycles, sb.pending());
      $display("nearest_point_matcher_unit_tb failed");
      $finish;
    end
  end

  // Random idle after an accepted beat; valid drops only when we actually idle.
  task automatic take_gap();
    int n;
    if (!quiet && $urandom_range(0, 99) < 8) begin
      in_valid_i <= 1'b0;
      n = $urandom_range(1, 4);
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_beat(logic cmd, logic [IdxW-1:0] idx, logic [CoordW-1:0] x,
                           logic [CoordW-1:0] y);
    in_valid_i    <= 1'b1;
    cmd_i         <= cmd;
    point_index_i <= idx;
    x_coord_i     <= x;
    y_coord_i     <= y;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(cmd, idx, x, y);
    if (cmd == CmdLoad) n_loads++;
    else n_queries++;
    take_gap();
  endtask

  task automatic load_point(int slot, int x, int y);
    send_beat(CmdLoad, IdxW'(slot), CoordW'(x), CoordW'(y));
  endtask

  task automatic query_point(int idx, int x, int y);
    send_beat(CmdQuery, IdxW'(idx), CoordW'(x), CoordW'(y));
  endtask

  // Sender holds off until every owed match has come back.
  task automatic drain_matches();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DistW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle: drained, then a trailing load let go.
  task automatic apply_setting(int count, logic [DistW-1:0] thresh);
    drain_matches();
    repeat (SettleCycles) @(posedge clk_i);
    write_reg(RegPointCount, DistW'(count));
    write_reg(RegFarThresh, thresh);
    n_settings++;
  endtask

  // Three in ten near an existing point so distances straddle the threshold.
  function automatic logic [CoordW-1:0] pick_coord(int base);
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = CoordMax;
      2, 3, 4: v = base + int'($urandom_range(0, 400)) - 200;
      default: v = $urandom_range(0, CoordMax);
    endcase
    if (v < 0) v = 0;
    if (v > CoordMax) v = CoordMax;
    return CoordW'(v);
  endfunction

  task automatic random_phase(int items, bit hold_mid);
    int n;
    int j;
    int s;
    for (int i = 0; i < items; i++) begin
      if (hold_mid && i == items / 2) drain_matches();
      if ($urandom_range(0, 99) < 70) begin
        n = sb.searched();
        j = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, MaxPoints - 1);
        send_beat(CmdQuery, IdxW'($urandom), pick_coord(int'(sb.pt_x[j])),
                  pick_coord(int'(sb.pt_y[j])));
      end else begin
        s = $urandom_range(0, MaxPoints - 1);
        j = $urandom_range(0, MaxPoints - 1);
        if ($urandom_range(0, 9) == 0)
          // exact duplicate of another slot forces distance ties
          send_beat(CmdLoad, IdxW'(s), sb.pt_x[j], sb.pt_y[j]);
        else
          send_beat(CmdLoad, IdxW'(s), pick_coord(int'(sb.pt_x[j])),
                    pick_coord(int'(sb.pt_y[j])));
      end
    end
  endtask

  initial begin
    sb            = new();
    quiet         = 1'b0;
    n_loads       = 0;
    n_queries     = 0;
    n_settings    = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    cmd_i         = CmdLoad;
    point_index_i = '0;
    x_coord_i     = '0;
    y_coord_i     = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: three slots at the corners, search only those.
    apply_setting(3, ThreshReset);
    load_point(0, 0, 0);
    load_point(1, CoordMax, CoordMax);
    load_point(2, 0, CoordMax);
    query_point(0, 0, 0);                 // exact hit on slot 0
    query_point(63, CoordMax, 0);         // slots 0 and 1 tie, lower wins
    query_point(21, 160, 0);              // exactly on the default threshold
    query_point(22, 161, 0);              // just past it
    load_point(0, CoordMax, CoordMax);    // slot 0 duplicates slot 1
    query_point(5, CoordMax, CoordMax);   // zero-distance tie
    load_point(0, 0, 0);
    apply_setting(3, '0);
    query_point(42, 0, 0);                // zero distance, zero threshold: not far
    query_point(43, 1, 0);
    apply_setting(1, NoMatchDist);
    query_point(63, CoordMax, CoordMax);  // largest possible distance
    apply_setting(0, ThreshReset);
    query_point(63, 5, 5);                // empty search

    // Fill the whole table so every later search reads written slots only.
    for (int s = 0; s < MaxPoints; s++)
      load_point(s, int'(pick_coord($urandom_range(0, CoordMax))),
                 int'(pick_coord($urandom_range(0, CoordMax))));

    apply_setting(64, ThreshReset);
    random_phase(90, 1'b1);
    apply_setting(127, DistW'($urandom));        // count above the table size
    random_phase(90, 1'b0);
    quiet = 1'b1;
    apply_setting(1, '0);
    random_phase(90, 1'b0);
    quiet = 1'b0;
    apply_setting(0, NoMatchDist);
    random_phase(60, 1'b0);
    apply_setting($urandom_range(2, 63), ThreshReset);
    random_phase(90, 1'b0);
    apply_setting(64, DistW'($urandom_range(0, 4000000)));
    random_phase(90, 1'b0);

    drain_matches();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Ran %0d point loads and %0d queries across %0d register settings.",
             n_loads, n_queries, n_settings);
    $display("Compared %0d match beats, %0d field mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("nearest_point_matcher_unit_tb passed");
    end else begin
      $display("nearest_point_matcher_unit_tb failed");
    end
    $finish;
  end

endmodule
